// ===== hdl/scadj_pkg.sv =====
package scadj_pkg;

    localparam int NUM_BANDS = 8;
    localparam int WW  = 17;   // one band weight, Q16
    localparam int SW  = 18;   // weight sum, at most three bands overlap
    localparam int PW  = 26;   // weight times code, signed
    localparam int CW  = 28;   // sum of weighted codes, signed
    localparam int NW  = 35;   // divider dividend
    localparam int DW  = 27;   // divider divisor
    localparam int QW  = 8;    // quotient
    localparam int LAT = 13;   // register stages from input to result

    // band code registers, index = byte address / 8
    typedef enum logic [1:0] {
        REG_HUE_SHIFT  = 2'd0,
        REG_SATURATION = 2'd1,
        REG_LIGHTNESS  = 2'd2
    } code_reg_t;

    localparam logic [8:0] BAND_CENTRE [NUM_BANDS] =
        '{9'd0, 9'd45, 9'd90, 9'd150, 9'd195, 9'd240, 9'd285, 9'd315};

    // full-strength hue span of the wrap: 180 units * 128
    localparam logic [14:0] HUE_FULL_MUL = 15'd23040;

    typedef struct packed {
        logic [7:0] sv;
        logic [7:0] lv;
        logic [7:0] h;
    } pixel_t;

    // raised-cosine window, round(65536*cos^2(2d deg)), zero from 45 up
    function automatic logic [WW-1:0] win_weight(input logic [5:0] d);
        logic [WW-1:0] w;
        unique case (d)
            6'd0:  w = 17'd65536;
            6'd1:  w = 17'd65456;
            6'd2:  w = 17'd65217;
            6'd3:  w = 17'd64820;
            6'd4:  w = 17'd64267;
            6'd5:  w = 17'd63560;
            6'd6:  w = 17'd62703;
            6'd7:  w = 17'd61700;
            6'd8:  w = 17'd60557;
            6'd9:  w = 17'd59278;
            6'd10: w = 17'd57870;
            6'd11: w = 17'd56339;
            6'd12: w = 17'd54694;
            6'd13: w = 17'd52942;
            6'd14: w = 17'd51092;
            6'd15: w = 17'd49152;
            6'd16: w = 17'd47133;
            6'd17: w = 17'd45043;
            6'd18: w = 17'd42894;
            6'd19: w = 17'd40695;
            6'd20: w = 17'd38458;
            6'd21: w = 17'd36193;
            6'd22: w = 17'd33912;
            6'd23: w = 17'd31624;
            6'd24: w = 17'd29343;
            6'd25: w = 17'd27078;
            6'd26: w = 17'd24841;
            6'd27: w = 17'd22642;
            6'd28: w = 17'd20493;
            6'd29: w = 17'd18403;
            6'd30: w = 17'd16384;
            6'd31: w = 17'd14444;
            6'd32: w = 17'd12594;
            6'd33: w = 17'd10842;
            6'd34: w = 17'd9197;
            6'd35: w = 17'd7666;
            6'd36: w = 17'd6258;
            6'd37: w = 17'd4979;
            6'd38: w = 17'd3836;
            6'd39: w = 17'd2833;
            6'd40: w = 17'd1976;
            6'd41: w = 17'd1269;
            6'd42: w = 17'd716;
            6'd43: w = 17'd319;
            6'd44: w = 17'd80;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/scadj_weight.sv =====
module scadj_weight
(
    input  logic                                            clk,
    input  logic                                            en,
    input  logic [7:0]                                      hue,
    input  logic [7:0]                                      lightness,
    input  logic [7:0]                                      saturation,
    output logic [scadj_pkg::NUM_BANDS-1:0][scadj_pkg::WW-1:0] w,
    output scadj_pkg::pixel_t                               pix
);

    logic [scadj_pkg::NUM_BANDS-1:0][scadj_pkg::WW-1:0] w_reg, w_next;
    scadj_pkg::pixel_t pix_reg, pix_next;
    logic [8:0] h2;
    logic [8:0] hdist [scadj_pkg::NUM_BANDS];
    logic [8:0] fold [scadj_pkg::NUM_BANDS];

    always_comb
    begin
        pix_next.h  = (hue >= 8'd180) ? hue - 8'd180 : hue;
        pix_next.lv = lightness;
        pix_next.sv = saturation;
        h2 = {pix_next.h, 1'b0};
        for (int b = 0; b < scadj_pkg::NUM_BANDS; b++)
        begin
            hdist[b] = (h2 >= scadj_pkg::BAND_CENTRE[b]) ? h2 - scadj_pkg::BAND_CENTRE[b]
                                                         : scadj_pkg::BAND_CENTRE[b] - h2;
            fold[b] = (hdist[b] > 9'd180) ? 9'd360 - hdist[b] : hdist[b];
            w_next[b] = (fold[b] < 9'd45) ? scadj_pkg::win_weight(fold[b][5:0]) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg   <= w_next;
            pix_reg <= pix_next;
        end
    end

    assign w   = w_reg;
    assign pix = pix_reg;

endmodule

// ===== hdl/scadj_accum.sv =====
module scadj_accum
(
    input  logic                                               clk,
    input  logic                                               en,
    input  logic [scadj_pkg::NUM_BANDS-1:0][scadj_pkg::WW-1:0] w,
    input  scadj_pkg::pixel_t                                  pix_in,
    input  logic [63:0]                                        hue_codes,
    input  logic [63:0]                                        sat_codes,
    input  logic [63:0]                                        light_codes,
    output logic [scadj_pkg::SW-1:0]                           wsum,
    output logic signed [scadj_pkg::CW-1:0]                    ch,
    output logic signed [scadj_pkg::CW-1:0]                    cs,
    output logic signed [scadj_pkg::CW-1:0]                    cl,
    output scadj_pkg::pixel_t                                  pix_out
);

    // stage A: per-band products
    logic [scadj_pkg::NUM_BANDS-1:0][scadj_pkg::WW-1:0] w_reg;
    logic signed [scadj_pkg::PW-1:0] ph_reg [scadj_pkg::NUM_BANDS];
    logic signed [scadj_pkg::PW-1:0] ps_reg [scadj_pkg::NUM_BANDS];
    logic signed [scadj_pkg::PW-1:0] pl_reg [scadj_pkg::NUM_BANDS];
    logic signed [scadj_pkg::PW-1:0] ph_next [scadj_pkg::NUM_BANDS];
    logic signed [scadj_pkg::PW-1:0] ps_next [scadj_pkg::NUM_BANDS];
    logic signed [scadj_pkg::PW-1:0] pl_next [scadj_pkg::NUM_BANDS];
    scadj_pkg::pixel_t pixa_reg;

    // stage B: sums
    logic [scadj_pkg::SW-1:0]        wsum_reg, wsum_next;
    logic signed [scadj_pkg::CW-1:0] ch_reg, ch_next, cs_reg, cs_next, cl_reg, cl_next;
    scadj_pkg::pixel_t pixb_reg;

    always_comb
    begin
        for (int b = 0; b < scadj_pkg::NUM_BANDS; b++)
        begin
            ph_next[b] = $signed({1'b0, w[b]}) * $signed(hue_codes[8*b +: 8]);
            ps_next[b] = $signed({1'b0, w[b]}) * $signed(sat_codes[8*b +: 8]);
            pl_next[b] = $signed({1'b0, w[b]}) * $signed(light_codes[8*b +: 8]);
        end
    end

    always_comb
    begin
        wsum_next = '0;
        ch_next   = '0;
        cs_next   = '0;
        cl_next   = '0;
        for (int b = 0; b < scadj_pkg::NUM_BANDS; b++)
        begin
            wsum_next = wsum_next + scadj_pkg::SW'(w_reg[b]);
            ch_next   = ch_next + scadj_pkg::CW'(ph_reg[b]);
            cs_next   = cs_next + scadj_pkg::CW'(ps_reg[b]);
            cl_next   = cl_next + scadj_pkg::CW'(pl_reg[b]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg    <= w;
            ph_reg   <= ph_next;
            ps_reg   <= ps_next;
            pl_reg   <= pl_next;
            pixa_reg <= pix_in;
            wsum_reg <= wsum_next;
            ch_reg   <= ch_next;
            cs_reg   <= cs_next;
            cl_reg   <= cl_next;
            pixb_reg <= pixa_reg;
        end
    end

    assign wsum    = wsum_reg;
    assign ch      = ch_reg;
    assign cs      = cs_reg;
    assign cl      = cl_reg;
    assign pix_out = pixb_reg;

endmodule

// ===== hdl/scadj_numer.sv =====
module scadj_numer
(
    input  logic                            clk,
    input  logic                            en,
    input  logic [scadj_pkg::SW-1:0]        wsum,
    input  logic signed [scadj_pkg::CW-1:0] ch,
    input  logic signed [scadj_pkg::CW-1:0] cs,
    input  logic signed [scadj_pkg::CW-1:0] cl,
    input  scadj_pkg::pixel_t               pix,
    output logic [scadj_pkg::NW-1:0]        num_h,
    output logic [scadj_pkg::DW-1:0]        den_h,
    output logic [scadj_pkg::NW-1:0]        num_l,
    output logic [scadj_pkg::DW-1:0]        den_l,
    output logic [scadj_pkg::NW-1:0]        num_s,
    output logic [scadj_pkg::DW-1:0]        den_s
);

    localparam int NW = scadj_pkg::NW;
    localparam int DW = scadj_pkg::DW;

    // push toward full (c > 0) or toward zero: n = v*f + (255-v)*c'
    function automatic logic [2*NW-1:0] push_terms(input logic [7:0] v,
                                                   input logic signed [scadj_pkg::CW-1:0] c,
                                                   input logic [DW-1:0] den);
        logic               pos;
        logic signed [28:0] f;
        logic [NW-1:0]      a;
        logic [NW-1:0]      b;
        pos = !c[scadj_pkg::CW-1] && (c != '0);
        f   = $signed({2'b00, den}) + (pos ? 29'sd0 : 29'(c));
        a   = NW'(v) * NW'(f[DW-1:0]);
        b   = pos ? NW'(8'd255 - v) * NW'(c[DW-1:0]) : '0;
        return {a, b};
    endfunction

    // stage A
    logic [24:0]          denh_reg, denh_next;
    logic [25:0]          denl_reg, denl_next;
    logic [32:0]          full_reg, full_next;
    logic signed [NW-1:0] hn_reg, hn_next;
    logic [NW-1:0]        sa_reg, sb_reg, la_reg, lb_reg;
    logic [2*NW-1:0]      s_terms, l_terms;
    logic [32:0]          hd;

    // stage B
    logic [NW-1:0]        nh_reg, nh_next, nl_reg, nl_next, ns_reg, ns_next;
    logic [DW-1:0]        dh_reg, dh_next, dl_reg, dl_next, ds_reg, ds_next;
    logic signed [NW-1:0] fulls;
    logic [NW-1:0]        hw, lsum, ssum;

    always_comb
    begin
        denh_next = {wsum, 7'b0};
        denl_next = {wsum, 8'b0};
        full_next = 33'(wsum) * 33'(scadj_pkg::HUE_FULL_MUL);
        hd        = 33'(pix.h) * 33'(denh_next);
        hn_next   = $signed({2'b00, hd}) + (NW'(ch) * 35'sd15);
        s_terms   = push_terms(pix.sv, cs, DW'(denh_next));
        l_terms   = push_terms(pix.lv, cl, DW'(denl_next));
    end

    always_comb
    begin
        fulls = $signed({2'b00, full_reg});
        if (hn_reg[NW-1])
            hw = NW'(hn_reg + fulls);
        else if (hn_reg >= fulls)
            hw = NW'(hn_reg - fulls);
        else
            hw = NW'(hn_reg);
        lsum    = la_reg + lb_reg;
        ssum    = sa_reg + sb_reg;
        // round half up: floor((2n + d) / 2d)
        nh_next = (hw << 1) + NW'(denh_reg);
        dh_next = DW'({denh_reg, 1'b0});
        nl_next = (lsum << 1) + NW'(denl_reg);
        dl_next = DW'({denl_reg, 1'b0});
        ns_next = (ssum << 1) + NW'(denh_reg);
        ds_next = DW'({denh_reg, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            denh_reg <= denh_next;
            denl_reg <= denl_next;
            full_reg <= full_next;
            hn_reg   <= hn_next;
            sa_reg   <= s_terms[2*NW-1:NW];
            sb_reg   <= s_terms[NW-1:0];
            la_reg   <= l_terms[2*NW-1:NW];
            lb_reg   <= l_terms[NW-1:0];
            nh_reg   <= nh_next;
            dh_reg   <= dh_next;
            nl_reg   <= nl_next;
            dl_reg   <= dl_next;
            ns_reg   <= ns_next;
            ds_reg   <= ds_next;
        end
    end

    assign num_h = nh_reg;
    assign den_h = dh_reg;
    assign num_l = nl_reg;
    assign den_l = dl_reg;
    assign num_s = ns_reg;
    assign den_s = ds_reg;

endmodule

// ===== hdl/scadj_div.sv =====
module scadj_div
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [scadj_pkg::NW-1:0] num,
    input  logic [scadj_pkg::DW-1:0] den,
    output logic [scadj_pkg::QW-1:0] quo
);

    localparam int NW = scadj_pkg::NW;
    localparam int DW = scadj_pkg::DW;
    localparam int QW = scadj_pkg::QW;

    // one quotient bit per stage, most significant first
    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_stage
            logic [NW-1:0] rem_in, trial;
            logic [DW-1:0] den_in;
            logic [QW-1:0] q_in;
            logic          take;

            if (s == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign q_in   = q_reg[s-1];
            end

            assign trial = NW'(den_in) << (QW - 1 - s);
            assign take  = (rem_in >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? rem_in - trial : rem_in;
                    den_reg[s] <= den_in;
                    q_reg[s]   <= q_in | (QW'(take) << (QW - 1 - s));
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW-1];

endmodule

// ===== hdl/hls_selective_color_adjust_top.sv =====
// Selective colour adjustment over eight hue bands on a stream of pixels in
// hue/lightness/saturation form (hue in 2-degree units). One pixel may enter
// every clock while the output is not stalled, and results leave in input
// order. The pipeline has one stage of band weighting, two of multiply and
// sum, two of numerator forming and wrap, and eight of the bit-per-stage
// restoring dividers (one per output). A stall on the output holds the
// whole pipeline. The three 64-bit band code registers sit at byte
// addresses 0, 8 and 16 and should be written only while no pixel is in
// flight; with no hue code set and every saturation and lightness code
// within one step of zero, pixels pass through unchanged.
module hls_selective_color_adjust_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hue_in, lightness_in, saturation_in

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // hue_out, lightness_out, saturation_out

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int LAT = scadj_pkg::LAT;

    // ---------------- configuration ----------------
    logic [63:0] hue_codes_reg, sat_codes_reg, light_codes_reg;
    logic        cfg_wr;
    logic        active;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_codes_reg   <= '0;
            sat_codes_reg   <= '0;
            light_codes_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                scadj_pkg::REG_HUE_SHIFT:  hue_codes_reg   <= pwdata;
                scadj_pkg::REG_SATURATION: sat_codes_reg   <= pwdata;
                scadj_pkg::REG_LIGHTNESS:  light_codes_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            scadj_pkg::REG_HUE_SHIFT:  prdata = hue_codes_reg;
            scadj_pkg::REG_SATURATION: prdata = sat_codes_reg;
            scadj_pkg::REG_LIGHTNESS:  prdata = light_codes_reg;
            default:   prdata = '0;
        endcase
    end

    // a band counts if its hue code is nonzero, or S/L code is not 0, +1 or -1
    always_comb
    begin
        active = 1'b0;
        for (int b = 0; b < scadj_pkg::NUM_BANDS; b++)
        begin
            if (hue_codes_reg[8*b +: 8] != 8'h00)
                active = 1'b1;
            if (sat_codes_reg[8*b +: 8] != 8'h00 && sat_codes_reg[8*b +: 8] != 8'h01 &&
                sat_codes_reg[8*b +: 8] != 8'hFF)
                active = 1'b1;
            if (light_codes_reg[8*b +: 8] != 8'h00 && light_codes_reg[8*b +: 8] != 8'h01 &&
                light_codes_reg[8*b +: 8] != 8'hFF)
                active = 1'b1;
        end
    end

    // ---------------- pipeline control ----------------
    // every stage advances together; the output register drains into m_*
    logic [LAT-1:0] vld_reg, vld_next;
    logic           pipe_en;

    assign pipe_en  = !vld_reg[LAT-1] || m_tready;
    assign s_tready = pipe_en;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= vld_next;
    end

    // ---------------- datapath ----------------
    logic [scadj_pkg::NUM_BANDS-1:0][scadj_pkg::WW-1:0] w;
    scadj_pkg::pixel_t               pix_w, pix_a;
    logic [scadj_pkg::SW-1:0]        wsum;
    logic signed [scadj_pkg::CW-1:0] ch, cs, cl;
    logic [scadj_pkg::NW-1:0]        num_h, num_l, num_s;
    logic [scadj_pkg::DW-1:0]        den_h, den_l, den_s;
    logic [scadj_pkg::QW-1:0]        q_h, q_l, q_s;

    scadj_weight u_weight
    (
        .clk        (clk),
        .en         (pipe_en),
        .hue        (s_tdata[7:0]),
        .lightness  (s_tdata[15:8]),
        .saturation (s_tdata[23:16]),
        .w          (w),
        .pix        (pix_w)
    );

    scadj_accum u_accum
    (
        .clk         (clk),
        .en          (pipe_en),
        .w           (w),
        .pix_in      (pix_w),
        .hue_codes   (hue_codes_reg),
        .sat_codes   (sat_codes_reg),
        .light_codes (light_codes_reg),
        .wsum        (wsum),
        .ch          (ch),
        .cs          (cs),
        .cl          (cl),
        .pix_out     (pix_a)
    );

    scadj_numer u_numer
    (
        .clk   (clk),
        .en    (pipe_en),
        .wsum  (wsum),
        .ch    (ch),
        .cs    (cs),
        .cl    (cl),
        .pix   (pix_a),
        .num_h (num_h),
        .den_h (den_h),
        .num_l (num_l),
        .den_l (den_l),
        .num_s (num_s),
        .den_s (den_s)
    );

    scadj_div u_div_h (.clk(clk), .en(pipe_en), .num(num_h), .den(den_h), .quo(q_h));
    scadj_div u_div_l (.clk(clk), .en(pipe_en), .num(num_l), .den(den_l), .quo(q_l));
    scadj_div u_div_s (.clk(clk), .en(pipe_en), .num(num_s), .den(den_s), .quo(q_s));

    // pass-through copy of the pixel, aligned with the divider outputs
    scadj_pkg::pixel_t byp_reg [LAT-1];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            byp_reg[0] <= pix_w;
            for (int i = 1; i < LAT - 1; i++)
                byp_reg[i] <= byp_reg[i-1];
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = active ? {q_s, q_l, q_h}
                             : {byp_reg[LAT-2].sv, byp_reg[LAT-2].lv, byp_reg[LAT-2].h};

    // ---------------- checks ----------------
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] <= 8'd180))
        else $error("hue result beyond 180");

    a_weight_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (wsum != '0))
        else $error("pixel with zero total band weight");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg) && $stable(q_h) && $stable(q_l) && $stable(q_s))
        else $error("pipeline moved during a stall");

    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

endmodule
